FILE: src/xoag_pkg.sv
// Shared types and constants for the x86 operand address generator.
// Holds operand kind, width and status codes, register file indexes and
// the item and result structs. No dependencies.
`timescale 1ns / 1ps

package xoag_pkg;

    // Register file geometry
    localparam int RF_DEPTH_DEF = 32;
    localparam int RF_DATA_W    = 32;
    localparam int REG_IDX_W    = 5;

    // Bank bases within the unified register file
    localparam logic [REG_IDX_W-1:0] SEG_BASE = 5'd9;
    localparam logic [REG_IDX_W-1:0] CR_BASE  = 5'd15;
    localparam logic [REG_IDX_W-1:0] DBG_BASE = 5'd20;

    // General registers used by 16-bit addressing
    localparam logic [REG_IDX_W-1:0] REG_BX = 5'd3;
    localparam logic [REG_IDX_W-1:0] REG_BP = 5'd5;
    localparam logic [REG_IDX_W-1:0] REG_SI = 5'd6;
    localparam logic [REG_IDX_W-1:0] REG_DI = 5'd7;

    // ModRM / SIB special codes
    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [4:0] RM32_SIB    = 5'd4;
    localparam logic [4:0] RM32_DISP   = 5'd5;
    localparam logic [4:0] RM16_DISP   = 5'd6;
    localparam logic [2:0] SIB_NO_IDX  = 3'd4;
    localparam logic [2:0] SIB_NO_BASE = 3'd5;

    // Operations
    localparam logic OP_RESOLVE = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    typedef enum logic [3:0] {
        K_IMM      = 4'd0,
        K_MEM      = 4'd1,
        K_MOFFSET  = 4'd2,
        K_MEM_DISP = 4'd3,
        K_REG      = 4'd4,
        K_REG8     = 4'd5,
        K_SEG      = 4'd6,
        K_CR       = 4'd7,
        K_DBG      = 4'd8,
        K_REL      = 4'd9,
        K_FARPTR   = 4'd10,
        K_SIB      = 4'd11
    } t_kind;

    typedef enum logic [2:0] {
        WC_NONE  = 3'd0,
        WC_BYTE  = 3'd1,
        WC_WORD  = 3'd2,
        WC_DWORD = 3'd3,
        WC_IMM8  = 3'd4,
        WC_IMM16 = 3'd5
    } t_wc;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RESERVED = 2'd1,
        ST_INVALID  = 2'd2,
        ST_NOWIDTH  = 2'd3
    } t_status;

    // One decoded input item
    typedef struct packed {
        logic                 op;
        t_kind                kind;
        logic [2:0]           wc;
        logic                 addr16;
        logic [1:0]           mode;
        logic [REG_IDX_W-1:0] rfield;
        logic [1:0]           scale;
        logic [2:0]           isel;
        logic [2:0]           bsel;
        logic [31:0]          disp;
        logic [31:0]          imm;
        logic [15:0]          sel;
    } t_item;

    // Register file read data, two ports
    typedef struct packed {
        logic [RF_DATA_W-1:0] a;
        logic [RF_DATA_W-1:0] b;
    } t_rd;

    // One result item
    typedef struct packed {
        logic [47:0] value;
        logic [5:0]  bits;
        logic        is_addr;
        t_status     status;
    } t_result;

endpackage

FILE: src/x86_operand_address_generator_unit.sv
// x86 operand address generator top level; uses xoag_pkg, xoag_regfile, xoag_resolve.
// A resolve transfer loads the read stage when it is accepted, then the result register
// when the read stage advances; the read stage holds it while the output is blocked.
// Throughput: one item per cycle, back to back; the input stalls only with both
// stages full and the output blocked. Write items give no result.
// Reset (synchronous, active low) empties both stages; the register file reads zero.
`timescale 1ns / 1ps

module x86_operand_address_generator_unit
    import xoag_pkg::*;
#(
    parameter int REGFILE_DEPTH = RF_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: width_code[2:0], addr16[3], mode[5:4], register_field[10:6],
    // scale[12:11], index_sel[15:13], base_sel[18:16], displacement[50:19],
    // immediate[82:51], segment_selector[98:83], zero[103:99]
    input  logic [103:0] i_s_axis_tdata,
    // tuser: operation[0], operand_kind[4:1]
    input  logic [4:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: value[47:0], value_bits[53:48], status[55:54]
    output logic [55:0]  o_m_axis_tdata,
    // tuser: is_address[0]
    output logic [0:0]   o_m_axis_tuser
);

    t_item   in_item;
    t_item   r_s1_item;
    logic    r_s1_valid;
    logic    n_s1_valid;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    t_rd     rd;
    logic    s_accept;
    logic    adv;
    logic    is_write;
    logic    is_resolve;

    // unpack the input transfer
    always_comb begin
        in_item.op     = i_s_axis_tuser[0];
        in_item.kind   = t_kind'(i_s_axis_tuser[4:1]);
        in_item.wc     = i_s_axis_tdata[2:0];
        in_item.addr16 = i_s_axis_tdata[3];
        in_item.mode   = i_s_axis_tdata[5:4];
        in_item.rfield = i_s_axis_tdata[10:6];
        in_item.scale  = i_s_axis_tdata[12:11];
        in_item.isel   = i_s_axis_tdata[15:13];
        in_item.bsel   = i_s_axis_tdata[18:16];
        in_item.disp   = i_s_axis_tdata[50:19];
        in_item.imm    = i_s_axis_tdata[82:51];
        in_item.sel    = i_s_axis_tdata[98:83];
    end

    // handshake
    assign adv             = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = adv || !r_s1_valid;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign is_write        = s_accept && (in_item.op == OP_WRITE);
    assign is_resolve      = s_accept && (in_item.op == OP_RESOLVE);

    xoag_regfile #(
        .DEPTH (REGFILE_DEPTH)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (is_write),
        .i_re    (is_resolve),
        .i_item  (in_item),
        .o_rd    (rd)
    );

    xoag_resolve u_resolve (
        .i_item (r_s1_item),
        .i_rd   (rd),
        .o_res  (res)
    );

    // read stage holds the item while its register reads come back
    always_comb begin
        if (is_resolve) begin
            n_s1_valid = 1'b1;
        end else if (adv) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_resolve) begin
            r_s1_item <= in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = {r_out.status, r_out.bits, r_out.value};
    assign o_m_axis_tuser[0] = r_out.is_addr;

    // input stalls only with both stages full and the output blocked
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_s1_valid && r_out_valid && !i_m_axis_tready))
        else $error("input stalled with room in the pipeline");

    // a resolve transfer always occupies the read stage next cycle
    a_resolve_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_resolve |=> r_s1_valid)
        else $error("resolve transfer lost");

    // a write transfer never creates a result
    a_write_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_write |=> !r_s1_valid)
        else $error("write transfer entered the result path");

    // error results carry status alone
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |->
        (r_out.value == '0 && r_out.bits == '0 && !r_out.is_addr))
        else $error("error result carries data");

endmodule

FILE: src/xoag_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module xoag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

FILE: src/xoag_regfile.sv
// Unified register file: RAM plus per-entry valid bits for the zero reset.
// Picks both read addresses from the incoming item. Uses xoag_pkg, xoag_ram.
`timescale 1ns / 1ps

module xoag_regfile
    import xoag_pkg::*;
#(
    parameter int DEPTH = RF_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic                 i_re,
    input  t_item                i_item,
    output t_rd                  o_rd
);

    localparam int AW = $clog2(DEPTH);

    logic [REG_IDX_W-1:0] addr_a;
    logic [REG_IDX_W-1:0] addr_b;
    logic                 in_a;
    logic                 in_b;
    logic                 in_w;
    logic                 we;
    logic                 byte_sel;
    logic [DEPTH-1:0]     r_valid;
    logic                 r_ok_a;
    logic                 r_ok_b;
    logic [RF_DATA_W-1:0] rdata_a;
    logic [RF_DATA_W-1:0] rdata_b;

    // read address selection; port A carries the base (the index for SIB),
    // port B the index (the base for SIB)
    always_comb begin
        byte_sel = (i_item.wc == WC_BYTE) || (i_item.kind == K_REG8);
        addr_a   = i_item.rfield;
        addr_b   = i_item.rfield;
        case (i_item.kind)
            K_SIB: begin
                addr_a = {2'b00, i_item.isel};
                addr_b = {2'b00, i_item.bsel};
            end
            K_MEM, K_MEM_DISP: begin
                if (i_item.addr16) begin
                    case (i_item.rfield[2:0])
                        3'd0, 3'd1, 3'd7: addr_a = REG_BX;
                        default:          addr_a = REG_BP;
                    endcase
                    addr_b = i_item.rfield[0] ? REG_DI : REG_SI;
                end
            end
            K_REG, K_REG8: begin
                // AH..BH live in bits 15:8 of the first four registers
                if (byte_sel && i_item.rfield[2]) begin
                    addr_a = {3'b000, i_item.rfield[1:0]};
                end
            end
            K_SEG:   addr_a = SEG_BASE + i_item.rfield;
            K_CR:    addr_a = CR_BASE + i_item.rfield;
            K_DBG:   addr_a = DBG_BASE + i_item.rfield;
            default: addr_a = i_item.rfield;
        endcase
    end

    // indexes past the depth read as zero and ignore writes
    assign in_a = ({1'b0, addr_a} < 6'(DEPTH));
    assign in_b = ({1'b0, addr_b} < 6'(DEPTH));
    assign in_w = ({1'b0, i_item.rfield} < 6'(DEPTH));
    assign we   = i_we && in_w;

    xoag_ram #(
        .WIDTH (RF_DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (i_item.rfield[AW-1:0]),
        .i_wdata   (i_item.imm),
        .i_re      (i_re),
        .i_raddr_a (addr_a[AW-1:0]),
        .i_raddr_b (addr_b[AW-1:0]),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // entry valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[i_item.rfield[AW-1:0]] <= 1'b1;
        end
    end

    // valid flags travel with the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_a <= 1'b0;
            r_ok_b <= 1'b0;
        end else if (i_re) begin
            r_ok_a <= in_a && r_valid[addr_a[AW-1:0]];
            r_ok_b <= in_b && r_valid[addr_b[AW-1:0]];
        end
    end

    assign o_rd.a = r_ok_a ? rdata_a : '0;
    assign o_rd.b = r_ok_b ? rdata_b : '0;

endmodule

FILE: src/xoag_resolve.sv
// Operand resolve logic: constant, register or effective address from an
// item and its two register reads. Uses xoag_pkg.
`timescale 1ns / 1ps

module xoag_resolve
    import xoag_pkg::*;
(
    input  t_item   i_item,
    input  t_rd     i_rd,
    output t_result o_res
);

    logic [47:0] val;
    logic [5:0]  bits;
    logic        isaddr;
    t_status     st;
    logic [5:0]  plain;
    logic        rf_bad;
    logic [31:0] d8;
    logic [31:0] d;
    logic [15:0] b16;
    logic [31:0] sib_idx;
    logic [31:0] sib_base;
    logic [31:0] sib_d;
    logic [31:0] sum32;

    always_comb begin
        // width codes 1..3
        case (i_item.wc)
            WC_BYTE:  plain = 6'd8;
            WC_WORD:  plain = 6'd16;
            WC_DWORD: plain = 6'd32;
            default:  plain = 6'd0;
        endcase

        rf_bad = (i_item.rfield[4:3] != 2'b00);
        d8     = {{24{i_item.disp[7]}}, i_item.disp[7:0]};
        d      = (i_item.mode == MOD_DISP8) ? d8 : i_item.disp;

        // 16-bit address term: base plus index, or base or index alone
        case (i_item.rfield[2:0])
            3'd4, 3'd5: b16 = i_rd.b[15:0];
            3'd6, 3'd7: b16 = i_rd.a[15:0];
            default:    b16 = i_rd.a[15:0] + i_rd.b[15:0];
        endcase

        // SIB terms
        sib_idx  = (i_item.isel == SIB_NO_IDX) ? '0 : (i_rd.a << i_item.scale);
        sib_base = (i_item.bsel == SIB_NO_BASE && i_item.mode == MOD_NODISP) ? '0 : i_rd.b;
        if (i_item.mode == MOD_DISP8) begin
            sib_d = d8;
        end else if (i_item.mode == MOD_DISP32 || i_item.bsel == SIB_NO_BASE) begin
            sib_d = i_item.disp;
        end else begin
            sib_d = '0;
        end
        sum32 = sib_base + sib_idx + sib_d;

        val    = '0;
        bits   = '0;
        isaddr = 1'b0;
        st     = ST_OK;

        if (i_item.wc > WC_IMM16) begin
            st = ST_NOWIDTH;
        end else begin
            case (i_item.kind)
                K_IMM: begin
                    case (i_item.wc)
                        WC_BYTE, WC_IMM8:  bits = 6'd8;
                        WC_WORD, WC_IMM16: bits = 6'd16;
                        WC_DWORD:          bits = 6'd32;
                        default:           bits = 6'd0;
                    endcase
                    case (bits)
                        6'd8:    val = {40'b0, i_item.imm[7:0]};
                        6'd16:   val = {32'b0, i_item.imm[15:0]};
                        6'd32:   val = {16'b0, i_item.imm};
                        default: st = ST_NOWIDTH;
                    endcase
                end
                K_MEM: begin
                    if (rf_bad) begin
                        st = ST_INVALID;
                    end else if (i_item.addr16) begin
                        if (i_item.rfield == RM16_DISP) begin
                            st = ST_INVALID;
                        end
                        val  = {32'b0, b16};
                        bits = 6'd16;
                    end else begin
                        if (i_item.rfield == RM32_SIB || i_item.rfield == RM32_DISP) begin
                            st = ST_INVALID;
                        end
                        val  = {16'b0, i_rd.a};
                        bits = 6'd32;
                    end
                    isaddr = 1'b1;
                end
                K_MOFFSET: begin
                    bits   = plain;
                    val    = {16'b0, i_item.disp};
                    isaddr = 1'b1;
                    if (plain == 6'd0) begin
                        st = ST_NOWIDTH;
                    end
                end
                K_MEM_DISP: begin
                    if (rf_bad || i_item.mode == MOD_REG) begin
                        st = ST_INVALID;
                    end else if (i_item.addr16) begin
                        if (i_item.mode == MOD_NODISP) begin
                            if (i_item.rfield != RM16_DISP) begin
                                st = ST_INVALID;
                            end
                            val = {32'b0, i_item.disp[15:0]};
                        end else begin
                            val = {32'b0, b16 + d[15:0]};
                        end
                        bits = 6'd16;
                    end else begin
                        if (i_item.mode == MOD_NODISP) begin
                            if (i_item.rfield != RM32_DISP) begin
                                st = ST_INVALID;
                            end
                            val = {16'b0, i_item.disp};
                        end else begin
                            if (i_item.rfield == RM32_SIB) begin
                                st = ST_INVALID;
                            end
                            val = {16'b0, i_rd.a + d};
                        end
                        bits = 6'd32;
                    end
                    isaddr = 1'b1;
                end
                K_REG, K_REG8: begin
                    if (rf_bad) begin
                        st = ST_INVALID;
                    end else if (i_item.wc == WC_BYTE || i_item.kind == K_REG8) begin
                        bits = 6'd8;
                        val  = {40'b0, (i_item.rfield[2] ? i_rd.a[15:8] : i_rd.a[7:0])};
                    end else if (i_item.wc == WC_WORD) begin
                        bits = 6'd16;
                        val  = {32'b0, i_rd.a[15:0]};
                    end else begin
                        bits = 6'd32;
                        val  = {16'b0, i_rd.a};
                    end
                end
                K_SEG: begin
                    if (rf_bad) begin
                        st = ST_INVALID;
                    end else if (i_item.rfield[2:1] == 2'b11) begin
                        st = ST_RESERVED;
                    end else begin
                        bits = 6'd16;
                        val  = {32'b0, i_rd.a[15:0]};
                    end
                end
                K_CR: begin
                    if (rf_bad) begin
                        st = ST_INVALID;
                    end else if (i_item.rfield == 5'd1 || i_item.rfield >= 5'd5) begin
                        st = ST_RESERVED;
                    end else begin
                        bits = 6'd32;
                        val  = {16'b0, i_rd.a};
                    end
                end
                K_DBG: begin
                    if (rf_bad) begin
                        st = ST_INVALID;
                    end else if (i_item.rfield == 5'd4 || i_item.rfield == 5'd5) begin
                        st = ST_RESERVED;
                    end else begin
                        bits = 6'd32;
                        val  = {16'b0, i_rd.a};
                    end
                end
                K_REL: begin
                    bits = plain;
                    case (plain)
                        6'd8:    val = {40'b0, i_item.imm[7:0]};
                        6'd16:   val = {32'b0, i_item.imm[15:0]};
                        6'd32:   val = {16'b0, i_item.imm};
                        default: st = ST_NOWIDTH;
                    endcase
                end
                K_FARPTR: begin
                    if (i_item.wc == WC_DWORD) begin
                        bits = 6'd48;
                        val  = {i_item.sel, i_item.imm};
                    end else begin
                        bits = 6'd32;
                        val  = {16'b0, i_item.sel, i_item.imm[15:0]};
                    end
                end
                K_SIB: begin
                    if (i_item.mode == MOD_REG) begin
                        st = ST_INVALID;
                    end
                    val    = {16'b0, sum32};
                    bits   = 6'd32;
                    isaddr = 1'b1;
                end
                default: st = ST_INVALID;
            endcase
        end

        // errors carry status only
        if (st != ST_OK) begin
            val    = '0;
            bits   = '0;
            isaddr = 1'b0;
        end

        o_res.value   = val;
        o_res.bits    = bits;
        o_res.is_addr = isaddr;
        o_res.status  = st;
    end

endmodule
